FILE: rtl/frp_pkg.sv
// frp_pkg: shared types and constants for the fasta record parser
// no dependencies; imported by fasta_record_parser
package frp_pkg;

  localparam int unsigned COUNT_BITS = 17;
  localparam int unsigned CMP_W      = 33;

  localparam logic [7:0] CHAR_HEADER  = 8'h3E;
  localparam logic [7:0] CHAR_COMMENT = 8'h23;
  localparam logic [7:0] CHAR_NL      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_GAP     = 8'h2D;
  localparam logic [7:0] CHAR_UC_A    = 8'h41;
  localparam logic [7:0] CHAR_UC_Z    = 8'h5A;
  localparam logic [7:0] CHAR_LC_A    = 8'h61;
  localparam logic [7:0] CHAR_LC_Z    = 8'h7A;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CASE_BIT     = 8'h20;

  localparam logic [15:0] MAX_RES_RESET = 16'd50000;

  typedef enum logic [1:0] {
    CFG_GAP_MARK       = 2'd0,
    CFG_MAX_RESIDUES   = 2'd1,
    CFG_ALLOW_DIGITS   = 2'd2,
    CFG_ALLOW_COMMENTS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_BLANKS = 3'd1,
    PH_NAME   = 3'd2,
    PH_TITLE  = 3'd3,
    PH_SEQ    = 3'd4,
    PH_SKIP   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_TITLE = 2'd1,
    KIND_RES   = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       status;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

FILE: rtl/fasta_record_parser.sv
// fasta_record_parser: byte-serial fasta text parser, one byte per clock when not stalled
// depends on frp_pkg for phase, kind and result types
//
// usage
//   input channel: in_byte_i / end_of_input_i with in_valid_i, in_stall_o.
//   a transaction moves one text byte, or the end of stream marker.
//   output channel: out_kind_o / out_char_o / out_status_o with out_valid_o,
//   out_stall_i. each byte gives zero or one result transaction.
//   config channel: cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i;
//   always ready, write only while the block is idle.
// timing
//   one byte is accepted per clock while in_stall_o is low. a result is
//   registered with its byte's update of the line phase and residue
//   counter, so the next byte may follow directly. an output register plus
//   one skid register part the two sides: a result goes to the skid register
//   when the output register is full and stalled, and in_stall_o rises only
//   once the skid register holds a result.
// reset
//   clears the parse state, the config registers to their defaults and both
//   output stages. after end of input every further byte is taken and dropped
//   until reset.
module fasta_record_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 end_of_input_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output frp_pkg::kind_e       out_kind_o,
  output logic [7:0]           out_char_o,
  output logic                 out_status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  frp_pkg::cfg_idx_e    cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import frp_pkg::*;

  logic [7:0]            gap_mark_q;
  logic [15:0]           max_res_q;
  logic                  allow_digits_q;
  logic                  allow_comments_q;

  phase_e                phase_q, phase_d;
  logic                  rec_open_q, rec_open_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic                  finished_q, finished_d;

  logic                  out_valid_q, skid_valid_q;
  result_t               out_q, skid_q;

  logic                  in_fire;
  logic                  res_valid;
  result_t               res;
  logic                  out_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_mark_q       <= CHAR_GAP;
      max_res_q        <= MAX_RES_RESET;
      allow_digits_q   <= 1'b0;
      allow_comments_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GAP_MARK:       gap_mark_q       <= cfg_data_i[7:0];
        CFG_MAX_RESIDUES:   max_res_q        <= cfg_data_i;
        CFG_ALLOW_DIGITS:   allow_digits_q   <= cfg_data_i[0];
        CFG_ALLOW_COMMENTS: allow_comments_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // parse step for the byte on the input
  always_comb begin
    logic                  seq_path;
    logic                  kept_ok;
    logic [7:0]            kept;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [7:0]            c;

    c          = in_byte_i;
    phase_d    = phase_q;
    rec_open_d = rec_open_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    finished_d = finished_q;
    res_valid  = 1'b0;
    res.kind   = KIND_END;
    res.ch     = 8'h00;
    res.status = 1'b0;
    seq_path   = 1'b0;
    kept_ok    = 1'b0;
    kept       = c;
    cnt_inc    = count_q + COUNT_BITS'(1);

    if (finished_q) begin
      res_valid = 1'b0;
    end else if (end_of_input_i) begin
      finished_d = 1'b1;
      phase_d    = PH_START;
      res_valid  = 1'b1;
      res.status = ovf_q;
      rec_open_d = 1'b0;
      count_d    = '0;
      ovf_d      = 1'b0;
    end else begin
      unique case (phase_q)
        PH_BLANKS: begin
          if (c == CHAR_NL) begin
            phase_d = PH_START;
          end else if (!is_blank(c)) begin
            phase_d   = PH_NAME;
            res_valid = 1'b1;
            res.kind  = KIND_NAME;
            res.ch    = c;
          end
        end
        PH_NAME: begin
          if (c == CHAR_NL) begin
            phase_d = PH_START;
          end else if (is_blank(c)) begin
            phase_d   = PH_TITLE;
            res_valid = 1'b1;
            res.kind  = KIND_TITLE;
            res.ch    = c;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_NAME;
            res.ch    = c;
          end
        end
        PH_TITLE: begin
          if (c == CHAR_NL) begin
            phase_d = PH_START;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_TITLE;
            res.ch    = c;
          end
        end
        PH_SEQ: seq_path = 1'b1;
        PH_SKIP: begin
          if (c == CHAR_NL) phase_d = PH_START;
        end
        default: begin
          if (c == CHAR_HEADER) begin
            phase_d = PH_BLANKS;
            if (rec_open_q) begin
              res_valid  = 1'b1;
              res.status = ovf_q;
              rec_open_d = 1'b0;
              count_d    = '0;
              ovf_d      = 1'b0;
            end
          end else if ((c == CHAR_COMMENT) && allow_comments_q) begin
            phase_d = PH_SKIP;
          end else begin
            rec_open_d = 1'b1;
            seq_path   = 1'b1;
          end
        end
      endcase

      if (seq_path) begin
        if (c == CHAR_NL) begin
          phase_d = PH_START;
        end else begin
          phase_d = PH_SEQ;
          priority if ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) begin
            kept_ok = 1'b1;
          end else if ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) begin
            kept_ok = 1'b1;
            kept    = c & ~CASE_BIT;
          end else if (c == gap_mark_q) begin
            kept_ok = 1'b1;
          end else if (allow_digits_q && (c >= CHAR_0) && (c <= CHAR_9)) begin
            kept_ok = 1'b1;
          end else begin
            kept_ok = 1'b0;
          end
          if (kept_ok) begin
            res_valid = 1'b1;
            res.kind  = KIND_RES;
            res.ch    = kept;
            if (CMP_W'(cnt_inc) > CMP_W'(max_res_q)) begin
              count_d = '0;
              ovf_d   = 1'b1;
            end else begin
              count_d = cnt_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      rec_open_q <= 1'b0;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      finished_q <= 1'b0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      rec_open_q <= rec_open_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      finished_q <= finished_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || (in_fire && res_valid);
      skid_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_q.kind;
  assign out_char_o   = out_q.ch;
  assign out_status_o = out_q.status;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_finished_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |=> finished_q)
    else $error("end of input flag cleared before reset");

  a_end_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && end_of_input_i && !finished_q) |=> (count_q == '0) && !ovf_q && !rec_open_q)
    else $error("record end at end of input left count or flags set");

  a_stalled_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
